// ===== rtl/core/sha_rrs_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the round-range stage.
// Depends on nothing; imported by sha_rrs_round and sha256_round_range_stage_core.
package sha_rrs_pkg;

    localparam int NUM_ROUNDS   = 64;
    localparam int ROUND_W      = 7;
    localparam int PKT_WORDS    = 32;
    localparam int CNT_W        = 5;
    localparam int RING_W       = 4;
    localparam int CFG_IDX_W    = 2;

    typedef logic [31:0]        word_t;
    typedef word_t [7:0]        vars_t;
    typedef logic [ROUND_W-1:0] round_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_STAGE = 2'd2;

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_s0(input word_t v);
        return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic word_t big_s1(input word_t v);
        return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic word_t small_s0(input word_t v);
        return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic word_t small_s1(input word_t v);
        return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha_rrs_round.sv =====
// One SHA-256 compression round on the eight working variables.
// Depends on sha_rrs_pkg for word types and the sigma functions.
module sha_rrs_round
    import sha_rrs_pkg::*;
(
    input  vars_t vars,
    input  word_t w,
    input  word_t k,
    output vars_t vars_new
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        // Index 0 is a, index 7 is h.
        ch       = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        maj      = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t1       = vars[7] + big_s1(vars[4]) + ch + k + w;
        t2       = big_s0(vars[0]) + maj;
        vars_new[7] = vars[6];
        vars_new[6] = vars[5];
        vars_new[5] = vars[4];
        vars_new[4] = vars[3] + t1;
        vars_new[3] = vars[2];
        vars_new[2] = vars[1];
        vars_new[1] = vars[0];
        vars_new[0] = t1 + t2;
    end

endmodule

// ===== rtl/core/sha256_round_range_stage_core.sv =====
// SHA-256 round-range stage: loads a 32-word packet, runs a range of rounds, emits results.
// Sequence: 32 input transfers, ring alignment and the ST_PRIME setup state (both
// skipped for an empty range), the rounds in order, ring realignment, then 8 or 32 output words.
// Packets are handled one at a time, the next being loaded only after the last output word;
// input is not taken while rounds run or while results are being emitted.
// Reset clears control state and restores the register defaults; packet storage is not cleared.
module sha256_round_range_stage_core
    import sha_rrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROUND_W-1:0]   cfg_data,
    input  logic                 word_valid,
    output logic                 word_ready,
    input  logic [31:0]          word,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [31:0]          out_word,
    output logic                 last
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ALIGN,
        ST_PRIME,
        ST_ROUND,
        ST_UNALIGN,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    round_t              first_round_reg, first_round_next;
    round_t              round_end_reg, round_end_next;
    logic                final_stage_reg, final_stage_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RING_W-1:0]   rot_reg, rot_next;
    round_t              round_reg, round_next;
    logic                res_valid_reg, res_valid_next;
    word_t               out_word_reg, out_word_next;
    logic                last_reg, last_next;

    // Packet storage: 0..7 initial hash, 8..15 a..h, 16..31 schedule ring.
    // The ring rotates so that entry 16 + j holds slot (rot_reg + j) mod 16.
    word_t               pkt_reg [PKT_WORDS];
    word_t               w_reg;
    word_t               k_reg;

    round_t              lo;
    round_t              hi;
    round_t              round_inc;
    logic                in_fire;
    logic                emit_fire;
    logic [CNT_W-1:0]    emit_last_cnt;
    vars_t               vars_cur;
    vars_t               vars_upd;
    word_t               w_prime;
    word_t               w_ahead;

    function automatic word_t sched_w(input round_t r, input word_t t0, input word_t t1,
                                      input word_t t9, input word_t t14);
        word_t ext;
        ext = small_s1(t14) + t9 + small_s0(t1) + t0;
        return (r < round_t'(16)) ? t0 : ext;
    endfunction

    assign lo = (first_round_reg > round_t'(NUM_ROUNDS)) ? round_t'(NUM_ROUNDS)
                                                        : first_round_reg;
    assign hi = (round_end_reg > round_t'(NUM_ROUNDS)) ? round_t'(NUM_ROUNDS)
                                                      : round_end_reg;
    assign round_inc     = round_reg + round_t'(1);
    assign in_fire       = word_valid && word_ready;
    assign emit_fire     = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);
    assign emit_last_cnt = final_stage_reg ? CNT_W'(7) : CNT_W'(PKT_WORDS - 1);

    // Schedule word for the first round, from the aligned ring.
    assign w_prime = sched_w(round_reg, pkt_reg[16], pkt_reg[17], pkt_reg[25], pkt_reg[30]);
    // Schedule word for the following round; the slot rewritten this cycle is not among
    // its taps, so it can be formed while the current round runs.
    assign w_ahead = sched_w(round_inc, pkt_reg[17], pkt_reg[18], pkt_reg[26], pkt_reg[31]);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            vars_cur[i] = pkt_reg[8 + i];
        end
    end

    sha_rrs_round u_round (
        .vars     (vars_cur),
        .w        (w_reg),
        .k        (k_reg),
        .vars_new (vars_upd)
    );

    assign cfg_ready  = 1'b1;
    assign word_ready = (state_reg == ST_LOAD);
    assign res_valid  = res_valid_reg;
    assign out_word   = out_word_reg;
    assign last       = last_reg;

    always_comb
    begin
        state_next       = state_reg;
        first_round_next = first_round_reg;
        round_end_next   = round_end_reg;
        final_stage_next = final_stage_reg;
        cnt_next         = cnt_reg;
        rot_next         = rot_reg;
        round_next       = round_reg;
        res_valid_next   = res_valid_reg;
        out_word_next    = out_word_reg;
        last_next        = last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_ROUND: first_round_next = cfg_data;
                CFG_ROUND_END:   round_end_next   = cfg_data;
                CFG_FINAL_STAGE: final_stage_next = cfg_data[0];
                default:         ;
            endcase
        end

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PKT_WORDS - 1))
                    begin
                        rot_next   = '0;
                        round_next = lo;
                        state_next = (lo < hi) ? ST_ALIGN : ST_UNALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (rot_reg == lo[RING_W-1:0])
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    rot_next = rot_reg + RING_W'(1);
                end
            end
            ST_PRIME:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rot_next   = rot_reg + RING_W'(1);
                round_next = round_inc;
                if (round_inc == hi)
                begin
                    state_next = ST_UNALIGN;
                end
            end
            ST_UNALIGN:
            begin
                if (rot_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    rot_next = rot_reg + RING_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    res_valid_next = 1'b1;
                    out_word_next  = final_stage_reg ? (pkt_reg[0] + pkt_reg[8]) : pkt_reg[0];
                    last_next      = (cnt_reg == emit_last_cnt);
                    if (cnt_reg == emit_last_cnt)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            first_round_reg <= '0;
            round_end_reg   <= round_t'(NUM_ROUNDS);
            final_stage_reg <= 1'b1;
            cnt_reg         <= '0;
            rot_reg         <= '0;
            round_reg       <= '0;
            res_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_round_reg <= first_round_next;
            round_end_reg   <= round_end_next;
            final_stage_reg <= final_stage_next;
            cnt_reg         <= cnt_next;
            rot_reg         <= rot_next;
            round_reg       <= round_next;
            res_valid_reg   <= res_valid_next;
            out_word_reg    <= out_word_next;
            last_reg        <= last_next;
        end
    end

    // Packet datapath: shifting on load and emit, ring rotation, round updates.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    for (int i = 0; i < PKT_WORDS - 1; i++)
                    begin
                        pkt_reg[i] <= pkt_reg[i + 1];
                    end
                    pkt_reg[PKT_WORDS - 1] <= word;
                end
            end
            ST_ALIGN:
            begin
                if (rot_reg != lo[RING_W-1:0])
                begin
                    for (int j = 0; j < 15; j++)
                    begin
                        pkt_reg[16 + j] <= pkt_reg[17 + j];
                    end
                    pkt_reg[31] <= pkt_reg[16];
                end
            end
            ST_PRIME:
            begin
                w_reg <= w_prime;
                k_reg <= ROUND_K[round_reg[5:0]];
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    pkt_reg[8 + i] <= vars_upd[i];
                end
                // Below round 16 the schedule word equals the slot itself, so it is
                // always written back as the ring turns.
                for (int j = 0; j < 15; j++)
                begin
                    pkt_reg[16 + j] <= pkt_reg[17 + j];
                end
                pkt_reg[31] <= w_reg;
                w_reg       <= w_ahead;
                k_reg       <= ROUND_K[round_inc[5:0]];
            end
            ST_UNALIGN:
            begin
                if (rot_reg != '0)
                begin
                    for (int j = 0; j < 15; j++)
                    begin
                        pkt_reg[16 + j] <= pkt_reg[17 + j];
                    end
                    pkt_reg[31] <= pkt_reg[16];
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    for (int i = 0; i < PKT_WORDS - 1; i++)
                    begin
                        pkt_reg[i] <= pkt_reg[i + 1];
                    end
                    pkt_reg[PKT_WORDS - 1] <= pkt_reg[0];
                end
            end
            default:
            begin
            end
        endcase
    end

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg >= lo) && (round_reg < hi))
        else $error("round index outside the configured range");

    a_ring_aligned_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rot_reg == '0))
        else $error("schedule ring not back in slot order before emission");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (cnt_reg == emit_last_cnt))
        |=> (state_reg == ST_LOAD) && (cnt_reg == '0) && last_reg)
        else $error("last word flagged while the run is still in progress");

    a_round_follows_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRIME) |=> (state_reg == ST_ROUND) && (round_reg == $past(round_reg)))
        else $error("round sequence did not start from the primed schedule word");

    a_no_emit_without_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_ROUND && state_reg == ST_UNALIGN) |-> (round_reg == hi))
        else $error("rounds stopped before the configured end");

endmodule
